// ===== rtl/bcd_pkg.sv =====
// Shared types for the checksum dedup block: controller states and the search token.
package bcd_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } bcd_state_type;

   // Search token handed from cell to cell along the table chain.
   typedef struct packed {
      logic valid;
      logic hit;
   } bcd_tok_type;

   localparam logic [7:0] FLETCHER_MOD = 8'd255;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

// ===== rtl/bcd_req_if.sv =====
// Request channel: one data byte per transaction with an end-of-block flag.
interface bcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/bcd_rsp_if.sv =====
// Response channel: checksum, length and dedup flags for one finished block.
interface bcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] checksum;
   logic [15:0] block_length;
   logic        seen_before;
   logic        recorded;

   modport source (output valid, output checksum, output block_length,
                   output seen_before, output recorded, input ready);
   modport sink (input valid, input checksum, input block_length,
                 input seen_before, input recorded, output ready);
endinterface

// ===== rtl/bcd_cell.sv =====
// One table cell: holds one stored checksum, compares it against the passing token.
module bcd_cell #(
   parameter int INDEX  = 0,
   parameter int FILL_W = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bcd_pkg::bcd_tok_type tok_in,
   input  logic [15:0]          key,
   input  logic [FILL_W-1:0]    fill,
   input  logic                 wr_en,
   output bcd_pkg::bcd_tok_type tok_out
);
   import bcd_pkg::*;

   logic [15:0]  entry_ff;
   bcd_tok_type  tok_ff;
   bcd_tok_type  tok_in_next;
   logic         occupied;
   logic         wr_here;

   assign occupied = FILL_W'(INDEX) < fill;
   assign wr_here  = wr_en && (fill == FILL_W'(INDEX));

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.hit   = tok_in.hit || (occupied && (entry_ff == key));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   // entries are only read below the fill count, so no reset
   always_ff @(posedge clock) begin
      if (wr_here) begin
         entry_ff <= key;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/bcd_chain.sv =====
// Row of table cells; the search token walks one cell per cycle.
module bcd_chain #(
   parameter int TABLE_DEPTH = 512,
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 launch,
   input  logic [15:0]          key,
   input  logic [FILL_W-1:0]    fill,
   input  logic                 wr_en,
   output bcd_pkg::bcd_tok_type tok_end
);
   import bcd_pkg::*;

   bcd_tok_type tok_link [TABLE_DEPTH+1];

   always_comb begin
      tok_link[0].valid = launch;
      tok_link[0].hit   = 1'b0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      bcd_cell #(
         .INDEX  (i),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_link[i]),
         .key     (key),
         .fill    (fill),
         .wr_en   (wr_en),
         .tok_out (tok_link[i+1])
      );
   end

   assign tok_end = tok_link[TABLE_DEPTH];

endmodule

// ===== rtl/block_checksum_dedup_top.sv =====
// Top level: Fletcher-16 over byte blocks with a cell-chain table of seen checksums.
//
//   channel  dir  handshake          contents
//   req      in   valid/ready        data_byte[7:0], last_byte
//   rsp      out  valid/ready        checksum[15:0], block_length[15:0], seen_before, recorded
//   csr      in   csr_wr_en          csr_wr_data = capture_enable
//
// Bytes are taken one per cycle while the controller is idle. A last byte that yields a response
// starts a search token down the TABLE_DEPTH-cell chain; req.ready stays low while the token
// walks through every cell and through finish, longer if rsp is stalled.
// A pending response does not block new bytes; only the next finish waits on it.
// Reset (synchronous) clears sums, count, fill count and capture_enable; table cells
// are not cleared, the fill count marks which are live.
module block_checksum_dedup_top #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   bcd_req_if.sink     req,
   bcd_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import bcd_pkg::*;

   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   bcd_state_type state_ff, state_in;

   logic              capture_ff;
   logic [7:0]        sum_low_ff, sum_low_in;
   logic [7:0]        sum_high_ff, sum_high_in;
   logic [15:0]       count_ff, count_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       key_ff;
   logic [15:0]       len_ff;
   logic              hit_ff;

   logic              rsp_valid_ff;
   logic [15:0]       rsp_checksum_ff;
   logic [15:0]       rsp_length_ff;
   logic              rsp_seen_ff;
   logic              rsp_recorded_ff;

   logic [8:0]        sl_sum, sh_sum;
   logic [7:0]        sl_next, sh_next;
   logic [15:0]       count_next;
   logic              accept;
   logic              qualify;
   logic              req_ready;
   logic              finish_go;
   logic              table_free;
   logic              store;
   bcd_tok_type       tok_end;

   // Fletcher sums: both stay below 255, so one conditional subtract reduces each.
   always_comb begin
      sl_sum  = {1'b0, sum_low_ff} + {1'b0, req.data_byte};
      sl_next = (sl_sum >= {1'b0, FLETCHER_MOD}) ? 8'(sl_sum - {1'b0, FLETCHER_MOD})
                                                 : sl_sum[7:0];
      sh_sum  = {1'b0, sum_high_ff} + {1'b0, sl_next};
      sh_next = (sh_sum >= {1'b0, FLETCHER_MOD}) ? 8'(sh_sum - {1'b0, FLETCHER_MOD})
                                                 : sh_sum[7:0];
      count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
   end

   assign accept  = req.valid && req_ready;
   assign qualify = accept && req.last_byte && capture_ff && (count_next > 16'd1);

   assign table_free = fill_ff < FILL_W'(TABLE_DEPTH);
   assign store      = finish_go && !hit_ff && table_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (qualify) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (tok_end.valid) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SEARCH: req_ready = 1'b0;
         ST_FINISH: finish_go = !rsp_valid_ff || rsp.ready;
         default:   req_ready = 1'b0;
      endcase
   end

   always_comb begin
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      count_in    = count_ff;
      if (accept) begin
         if (req.last_byte) begin
            sum_low_in  = '0;
            sum_high_in = '0;
            count_in    = '0;
         end else begin
            sum_low_in  = sl_next;
            sum_high_in = sh_next;
            count_in    = count_next;
         end
      end
      fill_in = store ? fill_ff + FILL_W'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capture_ff   <= 1'b0;
         sum_low_ff   <= '0;
         sum_high_ff  <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
         count_ff    <= count_in;
         fill_ff     <= fill_in;
         if (csr_wr_en) capture_ff <= csr_wr_data;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (qualify) begin
         key_ff <= {sh_next, sl_next};
         len_ff <= count_next;
      end
      if (state_ff == ST_SEARCH && tok_end.valid) begin
         hit_ff <= tok_end.hit;
      end
      if (finish_go) begin
         rsp_checksum_ff <= key_ff;
         rsp_length_ff   <= len_ff;
         rsp_seen_ff     <= hit_ff;
         rsp_recorded_ff <= !hit_ff && table_free;
      end
   end

   bcd_chain #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .launch  (qualify),
      .key     (qualify ? {sh_next, sl_next} : key_ff),
      .fill    (fill_ff),
      .wr_en   (store),
      .tok_end (tok_end)
   );

   assign req.ready        = req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.checksum     = rsp_checksum_ff;
   assign rsp.block_length = rsp_length_ff;
   assign rsp.seen_before  = rsp_seen_ff;
   assign rsp.recorded     = rsp_recorded_ff;

endmodule

// ===== rtl/bcd_checker.sv =====
// Port-level checks on the checksum dedup top, attached by bind.
module bcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_checksum,
   input logic [15:0] rsp_block_length,
   input logic        rsp_seen_before,
   input logic        rsp_recorded
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_seen_before && rsp_recorded))
      else $error("checksum both seen and recorded");

   a_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_block_length > 16'd1)
      else $error("response for a block shorter than two bytes");

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_checksum[7:0] != 8'hFF && rsp_checksum[15:8] != 8'hFF)
      else $error("checksum byte not reduced mod 255");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind block_checksum_dedup_top bcd_checker u_bcd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_checksum     (rsp.checksum),
   .rsp_block_length (rsp.block_length),
   .rsp_seen_before  (rsp.seen_before),
   .rsp_recorded     (rsp.recorded)
);
